>>> sv/kwsm_pkg.sv
// shared command and status codes for the k-way merge
package kwsm_pkg;

	localparam int CMD_W    = 2;
	localparam int LANE_F_W = 3;
	localparam int VALUE_W  = 32;
	localparam int STATUS_W = 3;
	localparam int CFG_W    = 4;

	localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH    = 2'd0,
		CMD_CLOSE   = 2'd1,
		CMD_POP     = 2'd2,
		CMD_RESTART = 2'd3
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK     = 3'd0,
		ST_WAIT   = 3'd1,
		ST_DONE   = 3'd2,
		ST_FULL   = 3'd3,
		ST_CLOSED = 3'd4
	} status_t;

endpackage

>>> sv/kwsm_ram.sv
// generic simple dual-port ram with registered read
module kwsm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> sv/k_way_sorted_merge.sv
// k-way merge of ascending signed lane fifos into one ascending stream
// a result appears in the output register in the cycle after its command transaction
// throughput: one command per cycle unless a result is held for the receiver; a pop picks
//   the minimum through a compare tree over the lane head registers, and the next head of
//   that lane is read from the lane ram and bypassed into the tree on the following cycle
// reset: all lanes empty and open, lanes_in_use 8, ram contents undefined
module k_way_sorted_merge #(
	parameter int LANES      = 8,
	parameter int FIFO_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [3:0]  cfg_data,   // lanes_in_use
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,    // lane[2:0], value[34:3], zero pad
	input  logic [1:0]  s_tuser,    // cmd[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,    // out_value[31:0], out_lane[34:32], zero pad
	output logic [2:0]  m_tuser     // status[2:0]
);

	localparam int LW = $clog2(LANES);
	localparam int PW = $clog2(FIFO_DEPTH);
	localparam int FW = $clog2(FIFO_DEPTH + 1);
	localparam int MEM_DEPTH = LANES * FIFO_DEPTH;
	localparam int AW = $clog2(MEM_DEPTH);
	localparam int P = 1 << LW;
	localparam int NODES = 2 * P - 1;
	localparam int VW = kwsm_pkg::VALUE_W;

	logic [kwsm_pkg::CFG_W-1:0] lanes_in_use_q;
	logic [VW-1:0] head_q [LANES];
	logic [FW-1:0] fill_q [LANES];
	logic [PW-1:0] rp_q [LANES];
	logic [PW-1:0] wp_q [LANES];
	logic [LANES-1:0] closed_q;
	logic pend_q;
	logic [LW-1:0] pend_lane_q;

	logic out_valid_q;
	kwsm_pkg::status_t status_q;
	logic [VW-1:0] out_value_q;
	logic [kwsm_pkg::LANE_F_W-1:0] out_lane_q;

	logic accept;
	kwsm_pkg::cmd_t cmd;
	logic [kwsm_pkg::LANE_F_W-1:0] lane_f;
	logic [VW-1:0] value_f;
	logic [LW-1:0] lane_idx;
	logic [kwsm_pkg::CFG_W-1:0] n_eff;
	logic [LANES-1:0] lane_en;
	logic lane_ok;
	logic [VW-1:0] rd_data;
	logic [VW-1:0] eff_head [LANES];
	logic waiting;
	logic any_fill;

	logic [VW-1:0] node_key [NODES];
	logic [LW-1:0] node_lane [NODES];
	logic node_vld [NODES];
	logic [VW-1:0] best_key;
	logic [LW-1:0] best_lane;
	logic best_vld;

	kwsm_pkg::status_t status_d;
	logic [VW-1:0] value_d;
	logic [kwsm_pkg::LANE_F_W-1:0] out_lane_d;
	logic push_ok;
	logic pop_ok;
	logic pop_refill;

	logic we;
	logic [AW-1:0] waddr;
	logic re;
	logic [AW-1:0] raddr;

	function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
		logic [PW-1:0] r;
		if (p == PW'(FIFO_DEPTH - 1)) begin
			r = '0;
		end else begin
			r = p + PW'(1);
		end
		return r;
	endfunction

	assign cmd      = kwsm_pkg::cmd_t'(s_tuser);
	assign lane_f   = s_tdata[2:0];
	assign value_f  = s_tdata[34:3];
	assign lane_idx = LW'(lane_f);

	assign cfg_ready = 1'b1;
	assign s_tready  = !out_valid_q || m_tready;
	assign accept    = s_tvalid && s_tready;

	always_comb begin
		if (lanes_in_use_q == '0) begin
			n_eff = kwsm_pkg::CFG_W'(1);
		end else if (32'(lanes_in_use_q) > LANES) begin
			n_eff = kwsm_pkg::CFG_W'(LANES);
		end else begin
			n_eff = lanes_in_use_q;
		end
	end

	assign lane_ok = 32'(lane_f) < 32'(n_eff);

	always_comb begin
		waiting  = 1'b0;
		any_fill = 1'b0;
		for (int i = 0; i < LANES; i++) begin
			lane_en[i] = 32'(i) < 32'(n_eff);
			if (pend_q && pend_lane_q == LW'(i)) begin
				eff_head[i] = rd_data;
			end else begin
				eff_head[i] = head_q[i];
			end
			if (lane_en[i] && fill_q[i] == '0 && !closed_q[i]) begin
				waiting = 1'b1;
			end
			if (fill_q[i] != '0) begin
				any_fill = 1'b1;
			end
		end
	end

	// minimum tree, ties to the left (lower lane)
	always_comb begin
		for (int i = 0; i < P; i++) begin
			if (i < LANES) begin
				node_key[P-1+i] = eff_head[i];
				node_vld[P-1+i] = lane_en[i] && fill_q[i] != '0;
			end else begin
				node_key[P-1+i] = '0;
				node_vld[P-1+i] = 1'b0;
			end
			node_lane[P-1+i] = LW'(i);
		end
		for (int n = P - 2; n >= 0; n--) begin
			if (node_vld[2*n+2] && (!node_vld[2*n+1] ||
					$signed(node_key[2*n+2]) < $signed(node_key[2*n+1]))) begin
				node_key[n]  = node_key[2*n+2];
				node_lane[n] = node_lane[2*n+2];
			end else begin
				node_key[n]  = node_key[2*n+1];
				node_lane[n] = node_lane[2*n+1];
			end
			node_vld[n] = node_vld[2*n+1] || node_vld[2*n+2];
		end
	end

	assign best_key  = node_key[0];
	assign best_lane = node_lane[0];
	assign best_vld  = node_vld[0];

	always_comb begin
		status_d   = kwsm_pkg::ST_OK;
		value_d    = '0;
		out_lane_d = '0;
		push_ok    = 1'b0;
		pop_ok     = 1'b0;
		case (cmd)
			kwsm_pkg::CMD_PUSH: begin
				if (!lane_ok || closed_q[lane_idx]) begin
					status_d = kwsm_pkg::ST_CLOSED;
				end else if (fill_q[lane_idx] == FW'(FIFO_DEPTH)) begin
					status_d = kwsm_pkg::ST_FULL;
				end else begin
					push_ok = 1'b1;
				end
			end
			kwsm_pkg::CMD_POP: begin
				if (waiting) begin
					status_d = kwsm_pkg::ST_WAIT;
				end else if (!best_vld) begin
					status_d = kwsm_pkg::ST_DONE;
				end else begin
					pop_ok     = 1'b1;
					value_d    = best_key;
					out_lane_d = kwsm_pkg::LANE_F_W'(best_lane);
				end
			end
			default: begin
			end
		endcase
	end

	assign pop_refill = pop_ok && fill_q[best_lane] > FW'(1);

	assign we    = accept && push_ok;
	assign waddr = AW'(AW'(lane_idx) * AW'(FIFO_DEPTH)) + AW'(wp_q[lane_idx]);
	assign re    = accept && pop_refill;
	assign raddr = AW'(AW'(best_lane) * AW'(FIFO_DEPTH)) + AW'(ptr_inc(rp_q[best_lane]));

	kwsm_ram #(
		.WIDTH(VW),
		.DEPTH(MEM_DEPTH)
	) u_lane_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(value_f),
		.re   (re),
		.raddr(raddr),
		.rdata(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lanes_in_use_q <= kwsm_pkg::CFG_RESET;
		end else if (cfg_valid && cfg_ready) begin
			lanes_in_use_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LANES; i++) begin
				fill_q[i] <= '0;
				rp_q[i]   <= '0;
				wp_q[i]   <= '0;
			end
			closed_q    <= '0;
			pend_q      <= 1'b0;
			pend_lane_q <= '0;
		end else if (accept) begin
			pend_q      <= pop_refill;
			pend_lane_q <= best_lane;
			case (cmd)
				kwsm_pkg::CMD_PUSH: begin
					if (push_ok) begin
						wp_q[lane_idx]   <= ptr_inc(wp_q[lane_idx]);
						fill_q[lane_idx] <= fill_q[lane_idx] + FW'(1);
					end
				end
				kwsm_pkg::CMD_CLOSE: begin
					if (lane_ok) begin
						closed_q[lane_idx] <= 1'b1;
					end
				end
				kwsm_pkg::CMD_POP: begin
					if (pop_ok) begin
						rp_q[best_lane]   <= ptr_inc(rp_q[best_lane]);
						fill_q[best_lane] <= fill_q[best_lane] - FW'(1);
					end
				end
				kwsm_pkg::CMD_RESTART: begin
					for (int i = 0; i < LANES; i++) begin
						fill_q[i] <= '0;
						rp_q[i]   <= '0;
						wp_q[i]   <= '0;
					end
					closed_q <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	// head registers: refill from ram, or direct load on push into an empty lane
	always_ff @(posedge clk) begin
		if (accept) begin
			if (pend_q) begin
				head_q[pend_lane_q] <= rd_data;
			end
			if (push_ok && fill_q[lane_idx] == '0) begin
				head_q[lane_idx] <= value_f;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q    <= status_d;
			out_value_q <= value_d;
			out_lane_q  <= out_lane_d;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = status_q;
	assign m_tdata  = {5'd0, out_lane_q, out_value_q};

	a_pend_lane_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> fill_q[pend_lane_q] != '0)
		else $error("head refill pending on an empty lane");

	a_restart_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && cmd == kwsm_pkg::CMD_RESTART |=> !any_fill && !pend_q)
		else $error("restart left lane data behind");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> m_tvalid)
		else $error("accepted command produced no result");

	a_fail_zero_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != kwsm_pkg::ST_OK |-> m_tdata == '0)
		else $error("non-ok result carries data");

endmodule

>>> tb/kwsm_merge_checker.sv
`timescale 1ns / 100ps
// checker that predicts each k-way merge result and compares it with the output stream
module kwsm_merge_checker #(
	parameter int LANES      = 8,
	parameter int FIFO_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [3:0]  cfg_data,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [39:0] s_tdata,
	input  logic [1:0]  s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [39:0] m_tdata,
	input  logic [2:0]  m_tuser,
	output int          errors,
	output int          pending
);

	typedef struct packed {
		kwsm_pkg::status_t                   status;
		logic signed [kwsm_pkg::VALUE_W-1:0] value;
		logic [kwsm_pkg::LANE_F_W-1:0]       lane;
	} merge_result_t;

	logic signed [kwsm_pkg::VALUE_W-1:0] lane_mem [LANES][FIFO_DEPTH];
	int unsigned                         rd_ptr [LANES];
	int unsigned                         wr_ptr [LANES];
	int unsigned                         fill [LANES];
	bit                                  closed [LANES];
	logic [kwsm_pkg::CFG_W-1:0]          lanes_reg;
	merge_result_t                       expected_q [$];
	merge_result_t                       exp_r;

	function automatic void clear_lanes();
		for (int i = 0; i < LANES; i++) begin
			rd_ptr[i] = 0;
			wr_ptr[i] = 0;
			fill[i]   = 0;
			closed[i] = 1'b0;
		end
	endfunction

	function automatic merge_result_t merge_command(input kwsm_pkg::cmd_t cmd,
			input logic [2:0] lane, input logic signed [kwsm_pkg::VALUE_W-1:0] value);
		merge_result_t r;
		int            n;
		bit            waiting;
		bit            found;
		int            best;
		r.status = kwsm_pkg::ST_OK;
		r.value  = '0;
		r.lane   = '0;
		n        = (lanes_reg == 0) ? 1 : (lanes_reg > LANES) ? LANES : int'(lanes_reg);
		waiting  = 1'b0;
		found    = 1'b0;
		best     = 0;
		case (cmd)
			kwsm_pkg::CMD_PUSH: begin
				if (int'(lane) >= n || closed[lane]) begin
					r.status = kwsm_pkg::ST_CLOSED;
				end else if (fill[lane] >= FIFO_DEPTH) begin
					r.status = kwsm_pkg::ST_FULL;
				end else begin
					lane_mem[lane][wr_ptr[lane]] = value;
					wr_ptr[lane] = (wr_ptr[lane] + 1) % FIFO_DEPTH;
					fill[lane]++;
				end
			end
			kwsm_pkg::CMD_CLOSE: begin
				if (int'(lane) < n)
					closed[lane] = 1'b1;
			end
			kwsm_pkg::CMD_POP: begin
				for (int i = 0; i < n; i++) begin
					if (fill[i] == 0) begin
						if (!closed[i])
							waiting = 1'b1;
					end else if (!found ||
							lane_mem[i][rd_ptr[i]] < lane_mem[best][rd_ptr[best]]) begin
						// strict less-than keeps ties on the lowest lane
						found = 1'b1;
						best  = i;
					end
				end
				if (waiting) begin
					r.status = kwsm_pkg::ST_WAIT;
				end else if (!found) begin
					r.status = kwsm_pkg::ST_DONE;
				end else begin
					r.value      = lane_mem[best][rd_ptr[best]];
					r.lane       = best[kwsm_pkg::LANE_F_W-1:0];
					rd_ptr[best] = (rd_ptr[best] + 1) % FIFO_DEPTH;
					fill[best]--;
				end
			end
			default: begin
				clear_lanes();
			end
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_lanes();
			lanes_reg = kwsm_pkg::CFG_RESET;
			expected_q.delete();
		end else begin
			if (cfg_valid && cfg_ready)
				lanes_reg = cfg_data;
			if (m_tvalid && m_tready) begin
				if (expected_q.size() == 0) begin
					$error("unexpected result transaction: status %0d value %0d lane %0d",
						m_tuser, $signed(m_tdata[31:0]), m_tdata[34:32]);
					errors++;
				end else begin
					exp_r = expected_q.pop_front();
					if (m_tuser !== exp_r.status) begin
						$error("status: expected %0d, got %0d", exp_r.status, m_tuser);
						errors++;
					end
					if (m_tdata[31:0] !== exp_r.value) begin
						$error("out_value: expected %0d, got %0d", exp_r.value,
							$signed(m_tdata[31:0]));
						errors++;
					end
					if (m_tdata[34:32] !== exp_r.lane) begin
						$error("out_lane: expected %0d, got %0d", exp_r.lane, m_tdata[34:32]);
						errors++;
					end
				end
			end
			if (s_tvalid && s_tready)
				expected_q.insert(expected_q.size(),
					merge_command(kwsm_pkg::cmd_t'(s_tuser), s_tdata[2:0], s_tdata[34:3]));
		end
		pending = expected_q.size();
	end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// testbench top for the k-way merge: clock, reset, stimulus, receiver stalls and verdict
module tb_top;

	localparam int LANES       = 8;
	localparam int FIFO_DEPTH  = 16;
	localparam int CYCLE_LIMIT = 400000;
	localparam int ITEM_TARGET = 600;
	localparam int HOLD_CYCLES = 300;
	localparam int HOLD_AT     = 300;

	typedef enum int {RX_ALWAYS, RX_MOSTLY, RX_RARELY, RX_TOGGLE} rx_mode_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [3:0]  cfg_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;
	logic [2:0]  m_tuser;

	int          errors;
	int          pending;
	int          burst_left;
	bit          idle_en;
	bit          hold_req;
	bit          hold_done;
	bit          hold_taken;
	int          items_sent;
	int          cycle_cnt;
	int          eff_lanes;
	int          phase;
	int          hold_left;
	int          mode_left;
	rx_mode_t    rx_mode;
	logic [3:0]  cfg_plan [5] = '{4'd1, 4'd15, 4'd0, 4'd8, 4'd2};

	k_way_sorted_merge #(
		.LANES      (LANES),
		.FIFO_DEPTH (FIFO_DEPTH)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	kwsm_merge_checker #(
		.LANES      (LANES),
		.FIFO_DEPTH (FIFO_DEPTH)
	) merge_chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.errors    (errors),
		.pending   (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycle_cnt = 0;
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("k_way_sorted_merge: mismatch");
		$finish;
	end

	// receiver stall patterns, plus one long hold-off on request
	initial begin
		m_tready   = 1'b0;
		hold_left  = 0;
		mode_left  = 0;
		hold_taken = 1'b0;
		rx_mode    = RX_ALWAYS;
		forever begin
			@(negedge clk);
			if (hold_req && !hold_taken) begin
				hold_left  = HOLD_CYCLES;
				hold_taken = 1'b1;
			end
			if (mode_left == 0) begin
				rx_mode   = rx_mode_t'($urandom_range(0, 3));
				mode_left = $urandom_range(16, 96);
			end
			mode_left--;
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				case (rx_mode)
					RX_ALWAYS: m_tready <= 1'b1;
					RX_MOSTLY: m_tready <= ($urandom_range(0, 3) != 0);
					RX_RARELY: m_tready <= ($urandom_range(0, 3) == 0);
					default:   m_tready <= ~m_tready;
				endcase
			end
		end
	end

	task automatic send_item(input kwsm_pkg::cmd_t cmd, input logic [2:0] lane,
			input logic [31:0] value);
		int gap;
		gap = 0;
		if (idle_en) begin
			if (burst_left == 0) begin
				gap        = $urandom_range(1, 8);
				burst_left = $urandom_range(1, 24);
			end else begin
				burst_left--;
			end
		end
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {5'b0, value, lane};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		items_sent++;
	endtask

	task automatic write_cfg(input logic [3:0] v);
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
		eff_lanes = (v == 0) ? 1 : (v > LANES) ? LANES : int'(v);
	endtask

	// one merge: optional restart, ascending pushes per lane mixed with pops,
	// closes, and some noise, then optionally enough pops to drain
	task automatic run_session(input bit fresh, input bit drain);
		int                 left [LANES];
		logic signed [31:0] next_val [LANES];
		bit                 shut [LANES];
		int                 open_cnt;
		int                 pushed;
		int                 pick;
		bit                 narrow;
		narrow   = ($urandom_range(0, 2) == 0);
		idle_en  = ($urandom_range(0, 3) != 0);
		open_cnt = eff_lanes;
		pushed   = 0;
		if (fresh)
			send_item(kwsm_pkg::CMD_RESTART, 3'($urandom_range(0, 7)), $urandom);
		for (int i = 0; i < LANES; i++) begin
			left[i] = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 18) : $urandom_range(0, 5);
			shut[i] = 1'b0;
			if (narrow)
				next_val[i] = $urandom_range(0, 8) - 4;
			else
				next_val[i] = $signed($urandom) >>> 1;
		end
		while (open_cnt > 0) begin
			if (!hold_done && items_sent > HOLD_AT) begin
				hold_req  = 1'b1;
				hold_done = 1'b1;
			end
			pick = $urandom_range(0, eff_lanes - 1);
			case ($urandom_range(0, 9))
				0: send_item(kwsm_pkg::cmd_t'($urandom_range(0, 3)),
					3'($urandom_range(0, 7)), $urandom);
				1, 2, 3: send_item(kwsm_pkg::CMD_POP, 3'($urandom_range(0, 7)), $urandom);
				default: begin
					if (left[pick] > 0) begin
						send_item(kwsm_pkg::CMD_PUSH, 3'(pick), next_val[pick]);
						if (narrow)
							next_val[pick] += $urandom_range(0, 2);
						else
							next_val[pick] += $urandom_range(0, 1 << 20);
						left[pick]--;
						pushed++;
					end else if (!shut[pick]) begin
						send_item(kwsm_pkg::CMD_CLOSE, 3'(pick), $urandom);
						shut[pick] = 1'b1;
						open_cnt--;
					end
				end
			endcase
		end
		if (drain)
			repeat (pushed + 2)
				send_item(kwsm_pkg::CMD_POP, 3'($urandom_range(0, 7)), $urandom);
	endtask

	initial begin
		arst_n     = 1'b0;
		cfg_valid  = 1'b0;
		cfg_data   = '0;
		s_tvalid   = 1'b0;
		s_tdata    = '0;
		s_tuser    = kwsm_pkg::CMD_PUSH;
		burst_left = 0;
		idle_en    = 1'b0;
		hold_req   = 1'b0;
		hold_done  = 1'b0;
		items_sent = 0;
		eff_lanes  = LANES;
		phase      = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: reset register value, extremes, closed and unused lanes, ties
		send_item(kwsm_pkg::CMD_POP,     3'd7, 32'hffff_ffff);
		send_item(kwsm_pkg::CMD_PUSH,    3'd0, 32'h8000_0000);
		send_item(kwsm_pkg::CMD_PUSH,    3'd7, 32'h7fff_ffff);
		send_item(kwsm_pkg::CMD_CLOSE,   3'd3, 32'h0);
		send_item(kwsm_pkg::CMD_CLOSE,   3'd3, 32'h0);
		send_item(kwsm_pkg::CMD_PUSH,    3'd3, 32'd5);
		send_item(kwsm_pkg::CMD_POP,     3'd0, 32'h0);
		send_item(kwsm_pkg::CMD_PUSH,    3'd5, 32'd42);
		write_cfg(4'd2);
		send_item(kwsm_pkg::CMD_PUSH,    3'd1, 32'h8000_0000);
		send_item(kwsm_pkg::CMD_PUSH,    3'd5, 32'd1);
		send_item(kwsm_pkg::CMD_CLOSE,   3'd6, 32'h0);
		send_item(kwsm_pkg::CMD_POP,     3'd0, 32'h0);
		send_item(kwsm_pkg::CMD_CLOSE,   3'd0, 32'h0);
		send_item(kwsm_pkg::CMD_POP,     3'd0, 32'h0);
		send_item(kwsm_pkg::CMD_POP,     3'd0, 32'h0);
		send_item(kwsm_pkg::CMD_CLOSE,   3'd1, 32'h0);
		send_item(kwsm_pkg::CMD_POP,     3'd0, 32'h0);
		write_cfg(4'd8);
		send_item(kwsm_pkg::CMD_POP,     3'd0, 32'h0);
		send_item(kwsm_pkg::CMD_RESTART, 3'd7, 32'hffff_ffff);
		send_item(kwsm_pkg::CMD_POP,     3'd0, 32'h0);

		items_sent = 0;
		while (items_sent < ITEM_TARGET) begin
			if (phase < 5)
				write_cfg(cfg_plan[phase]);
			else
				write_cfg(4'($urandom_range(0, 15)));
			repeat ($urandom_range(1, 3))
				run_session($urandom_range(0, 4) != 0, $urandom_range(0, 5) != 0);
			phase++;
		end

		@(negedge clk);
		s_tvalid <= 1'b0;
		for (int i = 0; i < 10000 && pending != 0; i++)
			@(negedge clk);
		repeat (8) @(negedge clk);
		if (errors == 0 && pending == 0)
			$display("k_way_sorted_merge: match");
		else
			$display("k_way_sorted_merge: mismatch");
		$finish;
	end

endmodule
